/* src/sn2_pkg.sv */
package sn2_pkg;

  // request commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // permutation table entries, a power of two
  localparam int TABLE_SIZE = 256;

  // skew and unskew factors
  localparam logic signed [33:0] SKEW_Q30    = 34'sd393016785;
  localparam logic signed [33:0] UNSKEW_Q30  = 34'sd226908346;
  localparam logic signed [23:0] UNSKEW_Q16  = 24'sd13849;
  localparam logic signed [23:0] UNSKEW2_Q16 = 24'sd27699;
  localparam logic signed [23:0] ONE_Q16     = 24'sd65536;
  localparam logic signed [49:0] HALF_Q32    = 50'sd2147483648;

  // offset word, 16 fraction bits
  typedef logic signed [23:0] offs_t;

  // entry mod 12 by restoring subtraction
  function automatic logic [3:0] mod12(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    for (int k = 4; k >= 0; k--) begin
      if (r >= (8'd12 << k)) begin
        r = r - (8'd12 << k);
      end
    end
    return r[3:0];
  endfunction

  // gradient dot product for one of twelve gradients
  function automatic logic signed [24:0] grad_dot(input logic [3:0] g,
                                                 input offs_t dx, input offs_t dy);
    logic signed [24:0] ex;
    logic signed [24:0] ey;
    ex = 25'(dx);
    ey = 25'(dy);
    case (g)
      4'd0:    return ex + ey;
      4'd1:    return -ex + ey;
      4'd2:    return ex - ey;
      4'd3:    return -ex - ey;
      4'd4:    return ex;
      4'd5:    return -ex;
      4'd6:    return ex;
      4'd7:    return -ex;
      4'd8:    return ey;
      4'd9:    return -ey;
      4'd10:   return ey;
      4'd11:   return -ey;
      default: return '0;
    endcase
  endfunction

endpackage

/* src/simplex_noise_2d.sv */
// A load request writes one table entry and gives no result; an evaluate request shows
// its result once the sequencer reaches its output state. A new request is accepted only
// in the idle state, so the pace of points is set by the single shared 34x34 multiplier
// (five products per corner) and six reads of the one-port table memory, the last three
// using the first three; a stalled earlier result holds the sequencer in its output state.
// Reset (synchronous, rst high) clears the sequencer and the output valid; the table
// memory is not cleared and holds nothing useful until loaded.
module simplex_noise_2d #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [7:0]         table_index,
  input  logic [7:0]         table_value,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] noise_value
);
  import sn2_pkg::*;

  // table must be a power of two
  localparam int AW  = $clog2(TABLE_SIZE);
  localparam int SW  = ((AW > 8) ? AW : 8) + 1;
  localparam int F   = COORD_FRAC_BITS;
  localparam int IW  = 34 - F;
  localparam int MW  = 34;
  localparam int PW  = 2 * MW;
  localparam int UW  = 36;
  localparam int OW  = 40;
  localparam int SH  = (F >= 16) ? (F - 16) : (16 - F);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SKEW0 = 5'd1;
  localparam logic [4:0] ST_SKEW1 = 5'd2;
  localparam logic [4:0] ST_CELL  = 5'd3;
  localparam logic [4:0] ST_UNSK0 = 5'd4;
  localparam logic [4:0] ST_UNSK1 = 5'd5;
  localparam logic [4:0] ST_OFFS  = 5'd6;
  localparam logic [4:0] ST_H0    = 5'd7;
  localparam logic [4:0] ST_H1    = 5'd8;
  localparam logic [4:0] ST_H2    = 5'd9;
  localparam logic [4:0] ST_H3    = 5'd10;
  localparam logic [4:0] ST_H4    = 5'd11;
  localparam logic [4:0] ST_H5    = 5'd12;
  localparam logic [4:0] ST_H6    = 5'd13;
  localparam logic [4:0] ST_K0    = 5'd14;
  localparam logic [4:0] ST_K1    = 5'd15;
  localparam logic [4:0] ST_K2    = 5'd16;
  localparam logic [4:0] ST_K3    = 5'd17;
  localparam logic [4:0] ST_K4    = 5'd18;
  localparam logic [4:0] ST_K5    = 5'd19;
  localparam logic [4:0] ST_K6    = 5'd20;
  localparam logic [4:0] ST_K7    = 5'd21;
  localparam logic [4:0] ST_K8    = 5'd22;
  localparam logic [4:0] ST_K9    = 5'd23;
  localparam logic [4:0] ST_OUT   = 5'd24;

  logic [4:0]            st;
  logic [1:0]            crn;
  logic signed [31:0]    px, py;
  logic signed [MW-1:0]  ma, mb;
  logic signed [PW-1:0]  prod;
  logic signed [33:0]    skew;
  logic signed [IW-1:0]  cell_i, cell_j;
  logic signed [UW-1:0]  unsk;
  offs_t                 x0, y0;
  logic                  lower;
  logic [7:0]            p0, p1, p2;
  logic [3:0]            g0, g1, g2;
  logic [47:0]           sq;
  logic                  tneg;
  logic signed [47:0]    acc;

  // table memory
  logic [7:0]            perm_mem [TABLE_SIZE];
  logic [7:0]            rdata;
  logic [AW-1:0]         rd_addr;
  logic [SW-1:0]         wr_full;

  // datapath helpers
  logic signed [34:0]    xs, ys;
  logic signed [OW-1:0]  offx, offy, offx_sh, offy_sh;
  offs_t                 dx, dy;
  logic [3:0]            gsel;
  logic signed [24:0]    dot;
  logic signed [49:0]    t_calc;
  logic signed [55:0]    sacc, scaled;
  logic signed [22:0]    val;
  logic signed [15:0]    sat;
  logic [AW-1:0]         ii, jj;
  logic [SW-1:0]         asum;

  assign in_stall = (st != ST_IDLE);
  assign wr_full  = SW'(table_index);

  // shared multiplier, one register after it
  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // table write on load, registered read
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall && command == CMD_LOAD) begin
      perm_mem[wr_full[AW-1:0]] <= table_value;
    end
    rdata <= perm_mem[rd_addr];
  end

  // cell and offset arithmetic
  always_comb begin
    xs      = 35'(px) + 35'(skew);
    ys      = 35'(py) + 35'(skew);
    offx    = OW'(px) - (OW'(cell_i) <<< F) + OW'(unsk);
    offy    = OW'(py) - (OW'(cell_j) <<< F) + OW'(unsk);
    offx_sh = (F >= 16) ? (offx >>> SH) : (offx <<< SH);
    offy_sh = (F >= 16) ? (offy >>> SH) : (offy <<< SH);
  end

  // hash addresses, all wrap mod table size
  always_comb begin
    ii   = cell_i[AW-1:0];
    jj   = cell_j[AW-1:0];
    asum = SW'(jj);
    unique case (st)
      ST_H1:   asum = SW'(jj) + SW'(!lower);
      ST_H2:   asum = SW'(jj) + SW'(1'b1);
      ST_H3:   asum = SW'(ii) + SW'(p0);
      ST_H4:   asum = SW'(ii) + SW'(lower) + SW'(p1);
      ST_H5:   asum = SW'(ii) + SW'(1'b1) + SW'(p2);
      default: asum = SW'(jj);
    endcase
    rd_addr = asum[AW-1:0];
  end

  // corner offsets and gradient
  always_comb begin
    case (crn)
      2'd1: begin
        dx   = x0 - (lower ? ONE_Q16 : '0) + UNSKEW_Q16;
        dy   = y0 - (lower ? '0 : ONE_Q16) + UNSKEW_Q16;
        gsel = g1;
      end
      2'd2: begin
        dx   = x0 - ONE_Q16 + UNSKEW2_Q16;
        dy   = y0 - ONE_Q16 + UNSKEW2_Q16;
        gsel = g2;
      end
      default: begin
        dx   = x0;
        dy   = y0;
        gsel = g0;
      end
    endcase
    dot    = grad_dot(gsel, dx, dy);
    t_calc = HALF_Q32 - $signed({2'b00, sq}) - $signed({2'b00, prod[47:0]});
  end

  // scale by 70 and saturate
  always_comb begin
    sacc   = 56'(acc);
    scaled = (sacc <<< 6) + (sacc <<< 2) + (sacc <<< 1);
    val    = scaled[55:33];
    if (val > 23'sd32767) begin
      sat = 16'sh7fff;
    end else if (val < -23'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = val[15:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      crn       <= '0;
      out_valid <= 1'b0;
    end else begin
      // output state reloads the result register itself
      if (out_valid && !out_stall && st != ST_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (in_valid && command == CMD_EVAL) begin
            px <= coord_x;
            py <= coord_y;
            ma <= MW'(coord_x) + MW'(coord_y);
            mb <= SKEW_Q30;
            st <= ST_SKEW0;
          end
        end
        ST_SKEW0: st <= ST_SKEW1;
        ST_SKEW1: begin
          skew <= prod[63:30];
          st   <= ST_CELL;
        end
        ST_CELL: begin
          cell_i <= xs[F +: IW];
          cell_j <= ys[F +: IW];
          st     <= ST_UNSK0;
        end
        ST_UNSK0: begin
          ma <= MW'(cell_i) + MW'(cell_j);
          mb <= UNSKEW_Q30;
          st <= ST_UNSK1;
        end
        ST_UNSK1: st <= ST_OFFS;
        ST_OFFS: begin
          unsk <= prod[(30 - F) +: UW];
          st   <= ST_H0;
        end
        ST_H0: begin
          x0    <= offx_sh[23:0];
          y0    <= offy_sh[23:0];
          lower <= $signed(offx_sh[23:0]) > $signed(offy_sh[23:0]);
          st    <= ST_H1;
        end
        ST_H1: begin
          p0 <= rdata;
          st <= ST_H2;
        end
        ST_H2: begin
          p1 <= rdata;
          st <= ST_H3;
        end
        ST_H3: begin
          p2 <= rdata;
          st <= ST_H4;
        end
        ST_H4: begin
          g0 <= mod12(rdata);
          st <= ST_H5;
        end
        ST_H5: begin
          g1 <= mod12(rdata);
          st <= ST_H6;
        end
        ST_H6: begin
          g2  <= mod12(rdata);
          crn <= '0;
          acc <= '0;
          st  <= ST_K0;
        end
        ST_K0: begin
          ma <= MW'(dx);
          mb <= MW'(dx);
          st <= ST_K1;
        end
        ST_K1: begin
          ma <= MW'(dy);
          mb <= MW'(dy);
          st <= ST_K2;
        end
        ST_K2: begin
          sq <= prod[47:0];
          st <= ST_K3;
        end
        ST_K3: begin
          tneg <= t_calc[49];
          ma   <= MW'({1'b0, t_calc[32:0]});
          mb   <= MW'({1'b0, t_calc[32:0]});
          st   <= ST_K4;
        end
        ST_K4: st <= ST_K5;
        ST_K5: begin
          ma <= MW'({2'b00, prod[63:32]});
          mb <= MW'({2'b00, prod[63:32]});
          st <= ST_K6;
        end
        ST_K6: st <= ST_K7;
        ST_K7: begin
          ma <= MW'({2'b00, prod[63:32]});
          mb <= MW'(dot);
          st <= ST_K8;
        end
        ST_K8: st <= ST_K9;
        ST_K9: begin
          if (!tneg) begin
            acc <= acc + $signed(prod[47:0]);
          end
          if (crn == 2'd2) begin
            st <= ST_OUT;
          end else begin
            crn <= crn + 2'd1;
            st  <= ST_K0;
          end
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            noise_value <= sat;
            out_valid   <= 1'b1;
            st          <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

endmodule

/* src/sn2_check.sv */
module sn2_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               command,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] noise_value
);
  import sn2_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(noise_value))
    else $error("stalled result changed");

  // an evaluate request occupies the block
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == CMD_EVAL |=> in_stall)
    else $error("block free right after evaluate request");

  // a load leaves the block free
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == CMD_LOAD |=> !in_stall)
    else $error("block busy after load request");

  // results only come from a busy block
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without evaluate in flight");

endmodule

bind simplex_noise_2d sn2_check u_sn2_check (.*);
